### rtl/core/cuvw_pkg.sv
// ============================================================================
// cuvw_pkg: shared types, constants and coefficient tables
// Fixed-point formats and per-sector folded coefficients, built at elaboration.
// ============================================================================
package cuvw_pkg;

	// fixed-point formats
	localparam int FRAC_BITS      = 6;
	localparam int COEF_FRAC_BITS = 16;

	localparam int POS_W   = 18;
	localparam int SEC_W   = 3;
	localparam int COEF_W  = COEF_FRAC_BITS + 3;
	localparam int CONST_W = FRAC_BITS + COEF_FRAC_BITS + 10;
	localparam int PROD_W  = POS_W + COEF_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int SQ_W    = 2 * POS_W;
	localparam int CMP_W   = SQ_W + 1;

	localparam int NUM_SECTORS = 6;

	// hit queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic signed [POS_W-1:0]   pos_t;
	typedef logic        [SEC_W-1:0]   sector_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [CONST_W-1:0] cterm_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic        [SQ_W-1:0]    sq_t;
	typedef logic        [CMP_W-1:0]   cmp_t;
	typedef logic        [QPTR_W-1:0]  qptr_t;
	typedef logic        [QCNT_W-1:0]  qcnt_t;

	// sector numbers, sector 0 centred on the positive x axis
	localparam sector_t SEC_0 = 3'd0;
	localparam sector_t SEC_1 = 3'd1;
	localparam sector_t SEC_2 = 3'd2;
	localparam sector_t SEC_3 = 3'd3;
	localparam sector_t SEC_4 = 3'd4;
	localparam sector_t SEC_5 = 3'd5;

	localparam pos_t COORD_MAX = 18'sh1FFFF;
	localparam pos_t COORD_MIN = -18'sh20000;

	// classified hit as it travels through the queue
	typedef struct packed {
		pos_t    x;
		pos_t    y;
		pos_t    z;
		sector_t sector;
	} hit_t;

	typedef struct packed {
		logic sat;
		pos_t val;
	} rnd_t;

	typedef struct packed {
		coef_t  ux;
		coef_t  uy;
		coef_t  uz;
		coef_t  vx;
		coef_t  vy;
		coef_t  vz;
		coef_t  wx;
		coef_t  wy;
		coef_t  wz;
		cterm_t uc;
		cterm_t vc;
		cterm_t wc;
	} coef_set_t;

	// geometry in Q24
	localparam longint Q_ONE          = 64'sd16777216;
	localparam longint Q_HALF         = 64'sd8388608;
	localparam longint SQ3_HALF       = 64'sd14529495;
	localparam longint COS_TILT       = 64'sd15205322;
	localparam longint SIN_TILT       = 64'sd7090357;
	localparam longint INV_SINRHO     = 64'sd18848145;
	localparam longint INV_TGRHO      = 64'sd8589385;
	localparam longint INV_TWO_COSRHO = 64'sd18407575;
	localparam longint Y_HI_Q         = 64'sd3186932843;
	localparam longint Y_LO_Q         = -64'sd3069794320;

	// divide by 2^s, nearest, ties away from zero
	function automatic longint round_shift(input longint v, input int s);
		longint r;
		if (s == 0) begin
			r = v;
		end else begin
			r = v + (longint'(1) << (s - 1));
			if (v < 0)
				r = r - longint'(1);
			r = r >>> s;
		end
		return r;
	endfunction

	function automatic longint mul_q24(input longint a, input longint b);
		return round_shift(a * b, 24);
	endfunction

	function automatic longint to_coef(input longint q24);
		return round_shift(q24, 24 - COEF_FRAC_BITS);
	endfunction

	function automatic longint to_const(input longint q24cm);
		return round_shift(q24cm * (longint'(1) << FRAC_BITS), 24 - COEF_FRAC_BITS);
	endfunction

	function automatic coef_set_t sector_coefs(input int k);
		longint c;
		longint s;
		longint ctc;
		longint cts;
		longint a1;
		longint a2;
		longint str;
		longint c1;
		coef_set_t r;
		case (k)
			0: begin c = Q_ONE;   s = 0;         end
			1: begin c = Q_HALF;  s = SQ3_HALF;  end
			2: begin c = -Q_HALF; s = SQ3_HALF;  end
			3: begin c = -Q_ONE;  s = 0;         end
			4: begin c = -Q_HALF; s = -SQ3_HALF; end
			default: begin c = Q_HALF; s = -SQ3_HALF; end
		endcase
		ctc  = mul_q24(COS_TILT, c);
		cts  = mul_q24(COS_TILT, s);
		a1   = mul_q24(ctc, INV_TGRHO);
		a2   = mul_q24(cts, INV_TGRHO);
		str  = mul_q24(SIN_TILT, INV_TGRHO);
		c1   = mul_q24(2 * Y_HI_Q - Y_LO_Q, INV_TGRHO);
		r.ux = COEF_W'(to_coef(mul_q24(ctc, INV_SINRHO)));
		r.uy = COEF_W'(to_coef(mul_q24(cts, INV_SINRHO)));
		r.uz = COEF_W'(to_coef(-mul_q24(SIN_TILT, INV_SINRHO)));
		r.uc = CONST_W'(to_const(mul_q24(-Y_LO_Q, INV_SINRHO)));
		r.vx = COEF_W'(to_coef(s - a1));
		r.vy = COEF_W'(to_coef(-c - a2));
		r.vz = COEF_W'(to_coef(str));
		r.vc = CONST_W'(to_const(c1));
		r.wx = COEF_W'(to_coef(mul_q24(-s - a1, INV_TWO_COSRHO)));
		r.wy = COEF_W'(to_coef(mul_q24(c - a2, INV_TWO_COSRHO)));
		r.wz = COEF_W'(to_coef(mul_q24(str, INV_TWO_COSRHO)));
		r.wc = CONST_W'(to_const(mul_q24(c1, INV_TWO_COSRHO)));
		return r;
	endfunction

	localparam coef_set_t COEF_TAB [NUM_SECTORS] = '{
		sector_coefs(0), sector_coefs(1), sector_coefs(2),
		sector_coefs(3), sector_coefs(4), sector_coefs(5)
	};

	localparam acc_t ACC_ONE  = acc_t'(1);
	localparam acc_t ACC_HALF = acc_t'(longint'(1) << (COEF_FRAC_BITS - 1));

	// round accumulator to an integer coordinate, then clip
	function automatic rnd_t round_sat(input acc_t acc);
		acc_t t;
		rnd_t r;
		t = acc + ACC_HALF;
		if (acc[ACC_W-1])
			t = t - ACC_ONE;
		t = t >>> COEF_FRAC_BITS;
		if (t > acc_t'(COORD_MAX)) begin
			r.sat = 1'b1;
			r.val = COORD_MAX;
		end else if (t < acc_t'(COORD_MIN)) begin
			r.sat = 1'b1;
			r.val = COORD_MIN;
		end else begin
			r.sat = 1'b0;
			r.val = t[POS_W-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/core/cuvw_front.sv
// ============================================================================
// cuvw_front: hit intake and sector classification
// Squares x and y in one registered stage, then sorts the hit into a sector.
// ============================================================================
module cuvw_front
	import cuvw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  pos_t x_pos,
	input  pos_t y_pos,
	input  pos_t z_pos,
	output logic out_valid,
	input  logic out_ready,
	output hit_t out_hit
);

	logic        valid_s1;
	pos_t        x_s1;
	pos_t        y_s1;
	pos_t        z_s1;
	sq_t         x2_s1;
	sq_t         y2_s1;
	logic signed [SQ_W-1:0] xw;
	logic signed [SQ_W-1:0] yw;
	cmp_t        x2c;
	cmp_t        y3c;
	sector_t     sec;

	assign in_ready = !valid_s1 || out_ready;
	assign xw = SQ_W'(x_pos);
	assign yw = SQ_W'(y_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			x_s1  <= x_pos;
			y_s1  <= y_pos;
			z_s1  <= z_pos;
			x2_s1 <= sq_t'(xw * xw);
			y2_s1 <= sq_t'(yw * yw);
		end
	end

	// compare 3*y^2 with x^2 against the 30-degree lines
	always_comb begin
		x2c = CMP_W'(x2_s1);
		y3c = CMP_W'(y2_s1) + (CMP_W'(y2_s1) << 1);
		if (x_s1 == '0 && y_s1 == '0)
			sec = SEC_0;
		else if (y3c < x2c)
			sec = (x_s1 > 0) ? SEC_0 : SEC_3;
		else if (y_s1 > 0)
			sec = (x_s1 > 0) ? SEC_1 : SEC_2;
		else
			sec = (x_s1 < 0) ? SEC_4 : SEC_5;
	end

	assign out_valid      = valid_s1;
	assign out_hit.x      = x_s1;
	assign out_hit.y      = y_s1;
	assign out_hit.z      = z_s1;
	assign out_hit.sector = sec;

endmodule

### rtl/core/cuvw_queue.sv
// ============================================================================
// cuvw_queue: short hit queue
// Decouples the classifier from the arithmetic pipeline.
// ============================================================================
module cuvw_queue
	import cuvw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  hit_t push_hit,
	output logic pop_valid,
	input  logic pop_ready,
	output hit_t pop_hit
);

	hit_t  mem_q [QDEPTH];
	qptr_t wr_ptr_q;
	qptr_t rd_ptr_q;
	qcnt_t count_q;
	logic  do_push;
	logic  do_pop;

	assign push_ready = (count_q != qcnt_t'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_hit    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == qptr_t'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == qptr_t'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_hit;
	end

endmodule

### rtl/core/cuvw_back.sv
// ============================================================================
// cuvw_back: plane coordinate pipeline
// Multiply by sector coefficients, sum, round and clip into the output register.
// ============================================================================
module cuvw_back
	import cuvw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  hit_t    in_hit,
	output logic    out_valid,
	input  logic    out_ready,
	output pos_t    u_coord,
	output pos_t    v_coord,
	output pos_t    w_coord,
	output sector_t sector,
	output logic    saturated
);

	coef_set_t cs;
	coef_set_t cs2;

	logic    valid_s1;
	sector_t sec_s1;
	prod_t   pux_s1, puy_s1, puz_s1;
	prod_t   pvx_s1, pvy_s1, pvz_s1;
	prod_t   pwx_s1, pwy_s1, pwz_s1;

	logic    valid_s2;
	sector_t sec_s2;
	acc_t    au_s2, av_s2, aw_s2;

	logic    valid_q;
	pos_t    u_q, v_q, w_q;
	sector_t sec_q;
	logic    sat_q;

	rnd_t    ru, rv, rw;
	logic    out_adv;
	logic    s2_ready;

	assign out_adv  = !valid_q || out_ready;
	assign s2_ready = !valid_s2 || out_adv;
	assign in_ready = !valid_s1 || s2_ready;

	assign cs  = COEF_TAB[in_hit.sector];
	assign cs2 = COEF_TAB[sec_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (s2_ready)
				valid_s2 <= valid_s1;
			if (out_adv)
				valid_q <= valid_s2;
		end
	end

	// stage 1: nine products
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sec_s1 <= in_hit.sector;
			pux_s1 <= prod_t'(in_hit.x) * prod_t'($signed(cs.ux));
			puy_s1 <= prod_t'(in_hit.y) * prod_t'($signed(cs.uy));
			puz_s1 <= prod_t'(in_hit.z) * prod_t'($signed(cs.uz));
			pvx_s1 <= prod_t'(in_hit.x) * prod_t'($signed(cs.vx));
			pvy_s1 <= prod_t'(in_hit.y) * prod_t'($signed(cs.vy));
			pvz_s1 <= prod_t'(in_hit.z) * prod_t'($signed(cs.vz));
			pwx_s1 <= prod_t'(in_hit.x) * prod_t'($signed(cs.wx));
			pwy_s1 <= prod_t'(in_hit.y) * prod_t'($signed(cs.wy));
			pwz_s1 <= prod_t'(in_hit.z) * prod_t'($signed(cs.wz));
		end
	end

	// stage 2: sums with the constant terms
	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			sec_s2 <= sec_s1;
			au_s2  <= acc_t'(pux_s1) + acc_t'(puy_s1) + acc_t'(puz_s1)
			          + acc_t'($signed(cs2.uc));
			av_s2  <= acc_t'(pvx_s1) + acc_t'(pvy_s1) + acc_t'(pvz_s1)
			          + acc_t'($signed(cs2.vc));
			aw_s2  <= acc_t'(pwx_s1) + acc_t'(pwy_s1) + acc_t'(pwz_s1)
			          + acc_t'($signed(cs2.wc));
		end
	end

	assign ru = round_sat(au_s2);
	assign rv = round_sat(av_s2);
	assign rw = round_sat(aw_s2);

	// stage 3: round, clip, hold for the receiver
	always_ff @(posedge clk) begin
		if (out_adv && valid_s2) begin
			u_q   <= ru.val;
			v_q   <= rv.val;
			w_q   <= rw.val;
			sec_q <= sec_s2;
			sat_q <= ru.sat | rv.sat | rw.sat;
		end
	end

	assign out_valid = valid_q;
	assign u_coord   = u_q;
	assign v_coord   = v_q;
	assign w_coord   = w_q;
	assign sector    = sec_q;
	assign saturated = sat_q;

endmodule

### rtl/core/calorimeter_hit_to_uvw_core.sv
// ============================================================================
// calorimeter_hit_to_uvw_core: lab hit position to calorimeter u, v, w
// Sector classification front end, hit queue and coefficient pipeline.
// ============================================================================
// Usage
//  - Slave stream carries one hit per item: x, y, z in 1/64 cm, signed.
//  - Master stream returns one item per hit: u, v, w (1/64 cm, rounded,
//    clipped), the azimuthal sector 0..5 and a flag set when any
//    coordinate was clipped. Items leave in arrival order.
//  - Throughput: one item per cycle while the receiver keeps m_tready high. The
//    accepting edge loads the squaring stage, then the queue slot and three
//    arithmetic stages (products, sums, round and clip) follow in order
//    before m_tvalid rises.
//  - The front squares x and y and classifies the sector; a four-entry queue
//    parts it from the back, which multiplies by per-sector coefficients
//    held in a constant table.
//  - Receiver stall: the output register holds its item; the back stalls,
//    the queue fills, and only then does s_tready drop.
//  - Reset (arst_n low) empties every stage and the queue at once; no valid
//    item survives it and no clearing pass follows.
// ============================================================================
module calorimeter_hit_to_uvw_core
	import cuvw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // x_pos[17:0], y_pos[35:18], z_pos[53:36], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // u[17:0], v[35:18], w[53:36], sector[56:54],
	                              // saturated[57], zero pad
);

	// front to queue
	logic    f_valid;
	logic    f_ready;
	hit_t    f_hit;

	// queue to back
	logic    q_valid;
	logic    q_ready;
	hit_t    q_hit;

	pos_t    u_coord;
	pos_t    v_coord;
	pos_t    w_coord;
	sector_t sector;
	logic    saturated;

	cuvw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.x_pos     (s_tdata[17:0]),
		.y_pos     (s_tdata[35:18]),
		.z_pos     (s_tdata[53:36]),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_hit   (f_hit)
	);

	cuvw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_hit   (f_hit),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_hit    (q_hit)
	);

	cuvw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_hit    (q_hit),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.u_coord   (u_coord),
		.v_coord   (v_coord),
		.w_coord   (w_coord),
		.sector    (sector),
		.saturated (saturated)
	);

	assign m_tdata = {6'b0, saturated, sector, w_coord, v_coord, u_coord};

endmodule
